// ===== src/ttg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ttg_pkg;

  // Input transaction modes.
  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_BENCH    = 2'd1,
    MODE_OVERTEMP = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYPASS         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AREA_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERSIST_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BENCH_HOT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BENCH_COLD     = 3'd4;

  // Configuration reset values.
  localparam logic [6:0] AREA_THRESHOLD_RST = 7'd50;
  localparam logic [5:0] PERSIST_LIMIT_RST  = 6'd30;
  localparam logic [6:0] BENCH_HOT_RST      = 7'd79;
  localparam logic [6:0] BENCH_COLD_RST     = 7'd70;

  // Sample substituted in bypass mode.
  localparam logic [6:0] ROOM_TEMP = 7'd25;

  // Counter widths and saturation points.
  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
  localparam logic [5:0]         PERSIST_MAX = 6'd63;

  // Average thresholds of the hot and cold ladders (average must exceed these).
  localparam int HOT_TOP   = 62;
  localparam int HOT_MID   = 59;
  localparam int HOT_LOW   = 57;
  localparam int COLD_TOP  = 54;
  localparam int COLD_HIGH = 52;
  localparam int COLD_MID  = 49;
  localparam int COLD_LOW  = 47;

  // Limit level codes.
  localparam logic [1:0] CPU_MAX = 2'd0;
  localparam logic [1:0] CPU_MID = 2'd1;
  localparam logic [1:0] CPU_LOW = 2'd2;
  localparam logic [1:0] CPU_MIN = 2'd3;
  localparam logic       GPU_MAX = 1'b0;
  localparam logic       GPU_LIM = 1'b1;

  // Held level codes meaning nothing issued yet.
  localparam logic [2:0] HELD_CPU_NONE = 3'd7;
  localparam logic [1:0] HELD_GPU_NONE = 2'd3;

  // Cold window hysteresis flag codes.
  localparam logic [1:0] CF_NONE = 2'd0;
  localparam logic [1:0] CF_MID  = 2'd1;
  localparam logic [1:0] CF_TOP  = 2'd2;

  typedef struct packed {
    logic       bypass;
    logic [6:0] area_threshold;
    logic [5:0] persist_limit;
    logic [6:0] bench_hot;
    logic [6:0] bench_cold;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic signed [7:0] sample_temp;
    logic signed [7:0] area_temp;
  } item_t;

  typedef struct packed {
    logic [1:0] cpu_level;
    logic       gpu_level;
  } lvl_t;

endpackage

`default_nettype wire

// ===== src/ttg_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_write,
  input  logic [ttg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ttg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ttg_pkg::cfg_t                    cfg
);
  import ttg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write transaction into the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      case (cfg_index)
        CFG_BYPASS:         cfg_nxt.bypass         = cfg_data[0];
        CFG_AREA_THRESHOLD: cfg_nxt.area_threshold = cfg_data;
        CFG_PERSIST_LIMIT:  cfg_nxt.persist_limit  = cfg_data[5:0];
        CFG_BENCH_HOT:      cfg_nxt.bench_hot      = cfg_data;
        CFG_BENCH_COLD:     cfg_nxt.bench_cold     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bypass         <= 1'b0;
      cfg_r.area_threshold <= AREA_THRESHOLD_RST;
      cfg_r.persist_limit  <= PERSIST_LIMIT_RST;
      cfg_r.bench_hot      <= BENCH_HOT_RST;
      cfg_r.bench_cold     <= BENCH_COLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/ttg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttg_core #(
  parameter int WINDOW_LENGTH = 20,
  parameter int SUM_WIDTH     = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  ttg_pkg::item_t item,
  input  ttg_pkg::cfg_t  cfg,
  output logic           res_valid,
  output ttg_pkg::lvl_t  res_lvl
);
  import ttg_pkg::*;

  // Comparing the window sum against (threshold + 1) * WINDOW_LENGTH is the same
  // as checking that the truncated average exceeds the threshold.
  localparam logic [SUM_WIDTH-1:0] HOT_TOP_SUM   = SUM_WIDTH'((HOT_TOP + 1) * WINDOW_LENGTH);
  localparam logic [SUM_WIDTH-1:0] HOT_MID_SUM   = SUM_WIDTH'((HOT_MID + 1) * WINDOW_LENGTH);
  localparam logic [SUM_WIDTH-1:0] HOT_LOW_SUM   = SUM_WIDTH'((HOT_LOW + 1) * WINDOW_LENGTH);
  localparam logic [SUM_WIDTH-1:0] COLD_TOP_SUM  = SUM_WIDTH'((COLD_TOP + 1) * WINDOW_LENGTH);
  localparam logic [SUM_WIDTH-1:0] COLD_HIGH_SUM = SUM_WIDTH'((COLD_HIGH + 1) * WINDOW_LENGTH);
  localparam logic [SUM_WIDTH-1:0] COLD_MID_SUM  = SUM_WIDTH'((COLD_MID + 1) * WINDOW_LENGTH);
  localparam logic [SUM_WIDTH-1:0] COLD_LOW_SUM  = SUM_WIDTH'((COLD_LOW + 1) * WINDOW_LENGTH);
  localparam logic [COUNT_W-1:0]   WINDOW_CNT    = COUNT_W'(WINDOW_LENGTH);

  logic [SUM_WIDTH-1:0] hot_sum_r, hot_sum_nxt;
  logic [SUM_WIDTH-1:0] cold_sum_r, cold_sum_nxt;
  logic [COUNT_W-1:0]   hot_count_r, hot_count_nxt;
  logic [COUNT_W-1:0]   cold_count_r, cold_count_nxt;
  logic [5:0]           persist_count_r, persist_count_nxt;
  logic                 hot_flag_r, hot_flag_nxt;
  logic [1:0]           cold_flag_r, cold_flag_nxt;
  logic [2:0]           held_cpu_r, held_cpu_nxt;
  logic [1:0]           held_gpu_r, held_gpu_nxt;

  logic [6:0]           pos_temp;
  logic                 temp_pos;
  logic                 hot_sel;
  logic [SUM_WIDTH-1:0] win_sum;
  logic [SUM_WIDTH:0]   sum_ext;
  logic [SUM_WIDTH-1:0] win_sum_sat;
  logic [COUNT_W-1:0]   win_count;
  logic [COUNT_W-1:0]   win_count_inc;
  logic                 win_done;
  logic [5:0]           persist_inc;

  logic                 lad_issue;
  lvl_t                 lad_lvl;
  logic                 lad_hf;
  logic [1:0]           lad_cf;
  logic [5:0]           lad_pc;
  logic                 lvl_change;

  // Sample after bypass, and the selected window's updated sum and count.
  always_comb begin
    pos_temp      = cfg.bypass ? ROOM_TEMP : item.sample_temp[6:0];
    temp_pos      = cfg.bypass || (!item.sample_temp[7] && (item.sample_temp[6:0] != 7'd0));
    hot_sel       = item.area_temp >= $signed({1'b0, cfg.area_threshold});
    win_sum       = hot_sel ? hot_sum_r : cold_sum_r;
    sum_ext       = {1'b0, win_sum} + {{(SUM_WIDTH - 6){1'b0}}, pos_temp};
    win_sum_sat   = sum_ext[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_ext[SUM_WIDTH-1:0];
    win_count     = hot_sel ? hot_count_r : cold_count_r;
    win_count_inc = (win_count == COUNT_MAX) ? win_count : win_count + 1'b1;
    win_done      = win_count_inc >= WINDOW_CNT;
    persist_inc   = (persist_count_r == PERSIST_MAX) ? persist_count_r
                                                     : persist_count_r + 1'b1;
  end

  // Level ladders of the hot and cold windows.
  always_comb begin
    lad_issue = 1'b1;
    lad_lvl   = '{cpu_level: CPU_LOW, gpu_level: GPU_LIM};
    lad_hf    = 1'b0;
    lad_cf    = CF_NONE;
    lad_pc    = persist_count_r;
    if (hot_sel) begin
      lad_hf = 1'b1;
      if (win_sum_sat >= HOT_TOP_SUM) begin
        lad_pc = persist_count_r;
      end else if (win_sum_sat >= HOT_MID_SUM) begin
        lad_pc = persist_inc;
        if ((persist_inc >= cfg.persist_limit) && hot_flag_r) begin
          lad_pc    = 6'd0;
          lad_issue = 1'b0;
        end
      end else begin
        lad_pc = 6'd0;
        if (!((win_sum_sat >= HOT_LOW_SUM) && hot_flag_r)) begin
          lad_lvl = '{cpu_level: CPU_MID, gpu_level: GPU_LIM};
          lad_hf  = 1'b0;
        end
      end
    end else begin
      if (win_sum_sat >= COLD_TOP_SUM) begin
        lad_pc = persist_inc;
        lad_cf = CF_TOP;
        if ((persist_inc >= cfg.persist_limit) && (cold_flag_r == CF_TOP)) begin
          lad_pc    = 6'd0;
          lad_issue = 1'b0;
        end
      end else begin
        lad_pc = 6'd0;
        if (win_sum_sat >= COLD_HIGH_SUM) begin
          if (cold_flag_r < CF_TOP) begin
            lad_lvl = '{cpu_level: CPU_MID, gpu_level: GPU_LIM};
            lad_cf  = CF_MID;
          end else begin
            lad_cf  = CF_TOP;
          end
        end else if (win_sum_sat >= COLD_MID_SUM) begin
          lad_lvl = '{cpu_level: CPU_MID, gpu_level: GPU_LIM};
          lad_cf  = CF_MID;
        end else if ((win_sum_sat >= COLD_LOW_SUM) && (cold_flag_r != CF_NONE)) begin
          lad_lvl = '{cpu_level: CPU_MID, gpu_level: GPU_LIM};
          lad_cf  = CF_MID;
        end else begin
          lad_lvl = '{cpu_level: CPU_MAX, gpu_level: GPU_MAX};
          lad_cf  = CF_NONE;
        end
      end
    end
    lvl_change = (held_cpu_r != {1'b0, lad_lvl.cpu_level}) ||
                 (held_gpu_r != {1'b0, lad_lvl.gpu_level});
  end

  // State update and result for the transaction leaving the input register.
  always_comb begin
    hot_sum_nxt       = hot_sum_r;
    cold_sum_nxt      = cold_sum_r;
    hot_count_nxt     = hot_count_r;
    cold_count_nxt    = cold_count_r;
    persist_count_nxt = persist_count_r;
    hot_flag_nxt      = hot_flag_r;
    cold_flag_nxt     = cold_flag_r;
    held_cpu_nxt      = held_cpu_r;
    held_gpu_nxt      = held_gpu_r;
    res_valid         = 1'b0;
    res_lvl           = lad_lvl;
    if (advance) begin
      case (item.mode)
        MODE_OVERTEMP: begin
          hot_count_nxt  = '0;
          cold_count_nxt = '0;
          res_valid      = 1'b1;
          res_lvl        = '{cpu_level: CPU_MIN, gpu_level: GPU_LIM};
        end
        MODE_BENCH: begin
          // Benchmark rule leaves all window state alone.
          if (temp_pos) begin
            if (pos_temp > cfg.bench_hot) begin
              res_valid = 1'b1;
              res_lvl   = '{cpu_level: CPU_MIN, gpu_level: GPU_LIM};
            end else if (pos_temp < cfg.bench_cold) begin
              res_valid = 1'b1;
              res_lvl   = '{cpu_level: CPU_MAX, gpu_level: GPU_MAX};
            end
          end
        end
        MODE_NORMAL: begin
          if (temp_pos) begin
            if (hot_sel) begin
              hot_sum_nxt    = win_done ? '0 : win_sum_sat;
              hot_count_nxt  = win_done ? '0 : win_count_inc;
              cold_sum_nxt   = '0;
              cold_count_nxt = '0;
            end else begin
              cold_sum_nxt   = win_done ? '0 : win_sum_sat;
              cold_count_nxt = win_done ? '0 : win_count_inc;
              hot_sum_nxt    = '0;
              hot_count_nxt  = '0;
            end
            if (win_done) begin
              persist_count_nxt = lad_pc;
              if (lad_issue) begin
                hot_flag_nxt  = lad_hf;
                cold_flag_nxt = lad_cf;
                if (lvl_change) begin
                  held_cpu_nxt = {1'b0, lad_lvl.cpu_level};
                  held_gpu_nxt = {1'b0, lad_lvl.gpu_level};
                  res_valid    = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_sum_r       <= '0;
      cold_sum_r      <= '0;
      hot_count_r     <= '0;
      cold_count_r    <= '0;
      persist_count_r <= '0;
      hot_flag_r      <= 1'b0;
      cold_flag_r     <= CF_NONE;
      held_cpu_r      <= HELD_CPU_NONE;
      held_gpu_r      <= HELD_GPU_NONE;
    end else begin
      hot_sum_r       <= hot_sum_nxt;
      cold_sum_r      <= cold_sum_nxt;
      hot_count_r     <= hot_count_nxt;
      cold_count_r    <= cold_count_nxt;
      persist_count_r <= persist_count_nxt;
      hot_flag_r      <= hot_flag_nxt;
      cold_flag_r     <= cold_flag_nxt;
      held_cpu_r      <= held_cpu_nxt;
      held_gpu_r      <= held_gpu_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ttg_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttg_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          res_valid,
  input  ttg_pkg::lvl_t res_lvl,
  input  logic          out_ready,
  output logic          out_valid,
  output ttg_pkg::lvl_t out_lvl,
  output logic          busy
);
  import ttg_pkg::*;

  logic out_valid_r, out_valid_nxt;
  lvl_t out_lvl_r, out_lvl_nxt;

  // A held result blocks the core until the receiver takes it.
  assign busy = out_valid_r && !out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_lvl_nxt   = out_lvl_r;
    if (advance) begin
      out_valid_nxt = res_valid;
      out_lvl_nxt   = res_lvl;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_lvl_r <= out_lvl_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_lvl   = out_lvl_r;

endmodule

`default_nettype wire

// ===== src/thermal_throttle_governor.sv =====
// Thermal throttle governor: turns a stream of temperature samples into CPU
// and GPU limit levels.
// Input channel (in_valid/in_ready): one transaction carries a mode, a sample
// and an area reading. Result channel (out_valid/out_ready): a transaction
// carries new CPU and GPU levels and appears only when a level is issued.
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high;
// write only while no input transaction is in flight.
// Throughput is one input transaction per cycle while no held result blocks
// the core. An accepted transaction waits in the input register, and its
// result, if any, is loaded into the output register at the edge on which
// it leaves. A single combinational pass from the input register updates
// the window state and forms the result for the output register.
// If the receiver stalls, the result stays in the output register, one more
// transaction may wait in the input register, and then in_ready drops.
// Synchronous reset clears all window state, marks no level as issued and
// loads the default configuration; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module thermal_throttle_governor #(
  parameter int WINDOW_LENGTH = 20,
  parameter int SUM_WIDTH     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_mode,
  input  logic signed [7:0]                in_sample_temp,
  input  logic signed [7:0]                in_area_temp,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_cpu_level,
  output logic                             out_gpu_level,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ttg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ttg_pkg::*;

  cfg_t  cfg;
  item_t item_r, item_nxt;
  logic  item_valid_r, item_valid_nxt;
  logic  advance;
  logic  busy;
  logic  res_valid;
  lvl_t  res_lvl;
  lvl_t  out_lvl;

  assign cfg_ready = 1'b1;

  ttg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register: drains whenever the output register can take a result.
  assign advance  = item_valid_r && !busy;
  assign in_ready = !item_valid_r || advance;

  always_comb begin
    item_valid_nxt = item_valid_r;
    item_nxt       = item_r;
    if (in_ready) begin
      item_valid_nxt = in_valid;
      item_nxt       = '{mode: mode_e'(in_mode), sample_temp: in_sample_temp,
                         area_temp: in_area_temp};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  ttg_core #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_lvl   (res_lvl)
  );

  ttg_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res_lvl   (res_lvl),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_lvl   (out_lvl),
    .busy      (busy)
  );

  assign out_cpu_level = out_lvl.cpu_level;
  assign out_gpu_level = out_lvl.gpu_level;

endmodule

`default_nettype wire

// ===== verif/thermal_throttle_governor_tb.sv =====
`timescale 1ns / 1ps

module thermal_throttle_governor_tb;
  import ttg_pkg::*;

  localparam int WIN_LEN      = 20;
  localparam int SUM_W        = 16;
  localparam int IDLE_PCT     = 29;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;

  logic                   clk            = 1'b0;
  logic                   rst_n          = 1'b0;
  logic                   in_valid       = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_mode        = MODE_NORMAL;
  logic signed [7:0]      in_sample_temp = '0;
  logic signed [7:0]      in_area_temp   = '0;
  logic                   out_valid;
  logic                   out_ready      = 1'b0;
  logic [1:0]             out_cpu_level;
  logic                   out_gpu_level;
  logic                   cfg_valid      = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index      = CFG_BYPASS;
  logic [CFG_DATA_W-1:0]  cfg_data       = '0;

  // Stimulus and scoreboard storage.
  item_t samples_pending[$];
  lvl_t  levels_due[$];
  item_t drv_item;
  item_t seen_item;
  lvl_t  seen_lv;
  lvl_t  want_lv;
  logic  in_taken    = 1'b0;
  bit    steady      = 1'b0;
  int    fed_cnt     = 0;
  int    faults      = 0;
  int    cycle_cnt   = 0;

  // Predictor copy of the configuration.
  logic       byp_on;
  logic [6:0] hot_area_min;
  logic [5:0] streak_limit;
  logic [6:0] bench_hi;
  logic [6:0] bench_lo;

  // Predictor copy of the window state.
  logic [SUM_W-1:0]   hot_acc;
  logic [SUM_W-1:0]   cold_acc;
  logic [COUNT_W-1:0] hot_n;
  logic [COUNT_W-1:0] cold_n;
  logic [5:0]         streak;
  logic               hot_hyst;
  logic [1:0]         cold_hyst;
  logic [2:0]         last_cpu;
  logic [1:0]         last_gpu;

  thermal_throttle_governor #(
    .WINDOW_LENGTH(WIN_LEN),
    .SUM_WIDTH    (SUM_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_sample_temp(in_sample_temp),
    .in_area_temp  (in_area_temp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cpu_level (out_cpu_level),
    .out_gpu_level (out_gpu_level),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Records the new levels and hysteresis flags; reports whether the levels moved.
  function automatic bit settle_levels(input logic [1:0] cpu, input logic gpu,
                                       input logic hh, input logic [1:0] ch,
                                       output lvl_t lv);
    bit fresh;
    fresh = (last_cpu != {1'b0, cpu}) || (last_gpu != {1'b0, gpu});
    if (fresh) begin
      last_cpu = {1'b0, cpu};
      last_gpu = {1'b0, gpu};
    end
    lv.cpu_level = cpu;
    lv.gpu_level = gpu;
    hot_hyst     = hh;
    cold_hyst    = ch;
    return fresh;
  endfunction

  // Hot window ladder.
  function automatic bit rank_hot(input int avg, output lvl_t lv);
    lv = '0;
    if (avg > HOT_TOP) return settle_levels(CPU_LOW, GPU_LIM, 1'b1, CF_NONE, lv);
    if (avg > HOT_MID) begin
      if (streak != PERSIST_MAX) streak++;
      // A long run in the upper band skips one re-issue.
      if (streak >= streak_limit && hot_hyst) begin
        streak = '0;
        return 1'b0;
      end
      return settle_levels(CPU_LOW, GPU_LIM, 1'b1, CF_NONE, lv);
    end
    streak = '0;
    if (avg > HOT_LOW && hot_hyst) return settle_levels(CPU_LOW, GPU_LIM, 1'b1, CF_NONE, lv);
    return settle_levels(CPU_MID, GPU_LIM, 1'b0, CF_NONE, lv);
  endfunction

  // Cold window ladder.
  function automatic bit rank_cold(input int avg, output lvl_t lv);
    lv = '0;
    if (avg > COLD_TOP) begin
      if (streak != PERSIST_MAX) streak++;
      if (streak >= streak_limit && cold_hyst == CF_TOP) begin
        streak = '0;
        return 1'b0;
      end
      return settle_levels(CPU_LOW, GPU_LIM, 1'b0, CF_TOP, lv);
    end
    streak = '0;
    if (avg > COLD_HIGH) begin
      if (cold_hyst < CF_TOP) return settle_levels(CPU_MID, GPU_LIM, 1'b0, CF_MID, lv);
      return settle_levels(CPU_LOW, GPU_LIM, 1'b0, CF_TOP, lv);
    end
    if (avg > COLD_MID) return settle_levels(CPU_MID, GPU_LIM, 1'b0, CF_MID, lv);
    if (avg > COLD_LOW) begin
      if (cold_hyst == CF_NONE) return settle_levels(CPU_MAX, GPU_MAX, 1'b0, CF_NONE, lv);
      return settle_levels(CPU_MID, GPU_LIM, 1'b0, CF_MID, lv);
    end
    return settle_levels(CPU_MAX, GPU_MAX, 1'b0, CF_NONE, lv);
  endfunction

  // Advances the predicted state by one input transaction.
  function automatic bit next_levels(input item_t it, output lvl_t lv);
    int             temp;
    int             avg;
    logic [SUM_W:0] wide;
    lv = '0;
    if (it.mode == MODE_OVERTEMP) begin
      hot_n        = '0;
      cold_n       = '0;
      lv.cpu_level = CPU_MIN;
      lv.gpu_level = GPU_LIM;
      return 1'b1;
    end
    if (it.mode == MODE_UNUSED) return 1'b0;
    if (byp_on) temp = int'(ROOM_TEMP);
    else temp = $signed(it.sample_temp);
    if (temp <= 0) return 1'b0;

    // Benchmark samples leave the window state alone; the hot rule wins.
    if (it.mode == MODE_BENCH) begin
      lv.cpu_level = CPU_MIN;
      lv.gpu_level = GPU_LIM;
      if (temp > int'(bench_hi)) return 1'b1;
      lv.cpu_level = CPU_MAX;
      lv.gpu_level = GPU_MAX;
      return temp < int'(bench_lo);
    end

    // Accumulate into the selected window and clear the other one.
    if (int'($signed(it.area_temp)) >= int'(hot_area_min)) begin
      wide    = {1'b0, hot_acc} + temp[SUM_W:0];
      hot_acc = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
      if (hot_n != COUNT_MAX) hot_n++;
      cold_acc = '0;
      cold_n   = '0;
    end else begin
      wide     = {1'b0, cold_acc} + temp[SUM_W:0];
      cold_acc = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
      if (cold_n != COUNT_MAX) cold_n++;
      hot_acc = '0;
      hot_n   = '0;
    end

    if (hot_n >= WIN_LEN) begin
      avg     = hot_acc / WIN_LEN;
      hot_acc = '0;
      hot_n   = '0;
      return rank_hot(avg, lv);
    end
    if (cold_n >= WIN_LEN) begin
      avg      = cold_acc / WIN_LEN;
      cold_acc = '0;
      cold_n   = '0;
      return rank_cold(avg, lv);
    end
    return 1'b0;
  endfunction

  // Driver: presents queued transactions, holds each until accepted.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (samples_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        drv_item = samples_pending.pop_front();
        in_valid       <= 1'b1;
        in_mode        <= drv_item.mode;
        in_sample_temp <= drv_item.sample_temp;
        in_area_temp   <= drv_item.area_temp;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: tracks configuration writes, predicts and checks results.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken     <= 1'b0;
      byp_on       = 1'b0;
      hot_area_min = AREA_THRESHOLD_RST;
      streak_limit = PERSIST_LIMIT_RST;
      bench_hi     = BENCH_HOT_RST;
      bench_lo     = BENCH_COLD_RST;
      hot_acc      = '0;
      cold_acc     = '0;
      hot_n        = '0;
      cold_n       = '0;
      streak       = '0;
      hot_hyst     = 1'b0;
      cold_hyst    = CF_NONE;
      last_cpu     = HELD_CPU_NONE;
      last_gpu     = HELD_GPU_NONE;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BYPASS:         byp_on       = cfg_data[0];
          CFG_AREA_THRESHOLD: hot_area_min = cfg_data[6:0];
          CFG_PERSIST_LIMIT:  streak_limit = cfg_data[5:0];
          CFG_BENCH_HOT:      bench_hi     = cfg_data[6:0];
          CFG_BENCH_COLD:     bench_lo     = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        seen_item.mode        = mode_e'(in_mode);
        seen_item.sample_temp = in_sample_temp;
        seen_item.area_temp   = in_area_temp;
        if (next_levels(seen_item, seen_lv)) levels_due.push_back(seen_lv);
      end
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          $display("%0t: result transaction with none expected, actual cpu_level %0d gpu_level %0d",
                   $time, out_cpu_level, out_gpu_level);
          faults++;
        end else begin
          want_lv = levels_due.pop_front();
          if (out_cpu_level !== want_lv.cpu_level) begin
            $display("%0t: cpu_level expected %0d, actual %0d",
                     $time, want_lv.cpu_level, out_cpu_level);
            faults++;
          end
          if (out_gpu_level !== want_lv.gpu_level) begin
            $display("%0t: gpu_level expected %0d, actual %0d",
                     $time, want_lv.gpu_level, out_gpu_level);
            faults++;
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Queues one input transaction; ignored ones are not counted.
  task automatic add_item(input mode_e m, input int sample, input int area);
    item_t it;
    it.mode        = m;
    it.sample_temp = sample[7:0];
    it.area_temp   = area[7:0];
    samples_pending.push_back(it);
    if (m == MODE_OVERTEMP || (m != MODE_UNUSED && (byp_on || $signed(it.sample_temp) > 0)))
      fed_cnt++;
  endtask

  task automatic add_noise();
    add_item(mode_e'($urandom_range(3)), int'($urandom_range(255)) - 128,
             int'($urandom_range(255)) - 128);
  endtask

  // Area reading that lands in the requested window under the current threshold.
  function automatic int area_for(input bit hot);
    if (hot) return int'(hot_area_min) + int'($urandom_range(127 - int'(hot_area_min)));
    return int'($urandom_range(int'(hot_area_min) + 127)) - 128;
  endfunction

  // Target averages cluster around the ladder steps and the upper bands.
  function automatic int pick_avg(input bit hot);
    case ($urandom_range(3))
      0:       return hot ? int'($urandom_range(65, 56)) : int'($urandom_range(57, 46));
      1:       return hot ? int'($urandom_range(62, 60)) : int'($urandom_range(60, 55));
      default: return int'($urandom_range(126, 1));
    endcase
  endfunction

  // One full window whose truncated average is avg, with paired jitter.
  task automatic add_window(input bit hot, input int avg);
    int rem;
    int lim;
    int d;
    int s[WIN_LEN];
    rem = $urandom_range(WIN_LEN - 1);
    for (int i = 0; i < WIN_LEN; i++) s[i] = avg + ((i < rem) ? 1 : 0);
    lim = (avg - 1 < 126 - avg) ? avg - 1 : 126 - avg;
    if (lim > 6) lim = 6;
    for (int i = 0; i + 1 < WIN_LEN; i += 2) begin
      d = $urandom_range(lim);
      s[i]     += d;
      s[i + 1] -= d;
    end
    for (int i = 0; i < WIN_LEN; i++) begin
      if ($urandom_range(99) < 2) add_noise();
      add_item(MODE_NORMAL, s[i], area_for(hot));
    end
  endtask

  // Mostly window bursts, with noise and benchmark samples near the thresholds.
  task automatic run_random(input int n);
    int stop;
    int pick;
    int s;
    bit hot;
    stop = fed_cnt + n;
    while (fed_cnt < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        hot = $urandom_range(1);
        repeat ($urandom_range(4, 1)) add_window(hot, pick_avg(hot));
      end else if (pick < 85) begin
        add_noise();
      end else begin
        case ($urandom_range(2))
          0:       s = int'(bench_hi) + int'($urandom_range(2)) - 1;
          1:       s = int'(bench_lo) + int'($urandom_range(2)) - 1;
          default: s = int'($urandom_range(255)) - 128;
        endcase
        add_item(MODE_BENCH, s, int'($urandom_range(255)) - 128);
      end
    end
  endtask

  // Waits until every transaction is accepted and every result has arrived.
  task automatic settle();
    do @(posedge clk);
    while (samples_pending.size() != 0 || in_valid || levels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: events, unused mode, benchmark edges, ignored samples, window select.
    add_item(MODE_OVERTEMP, -128, -128);
    add_item(MODE_UNUSED, 127, 127);
    add_item(MODE_BENCH, 127, 0);
    add_item(MODE_BENCH, 80, 0);
    add_item(MODE_BENCH, 79, 0);
    add_item(MODE_BENCH, 70, 0);
    add_item(MODE_BENCH, 69, 0);
    add_item(MODE_BENCH, 1, 0);
    add_item(MODE_BENCH, 0, 0);
    add_item(MODE_BENCH, -128, 0);
    add_item(MODE_NORMAL, 0, 127);
    add_item(MODE_NORMAL, -1, -128);
    add_item(MODE_NORMAL, -128, 0);
    add_item(MODE_OVERTEMP, 127, 127);
    add_item(MODE_NORMAL, 127, 127);
    add_item(MODE_NORMAL, 1, -128);
    add_item(MODE_NORMAL, 127, 50);
    add_item(MODE_NORMAL, 127, 49);
    run_random(100);
    settle();

    // Low extremes of the thresholds; both benchmark rules apply at once.
    write_reg(CFG_BYPASS, 0);
    write_reg(CFG_AREA_THRESHOLD, 0);
    write_reg(CFG_PERSIST_LIMIT, 1);
    write_reg(CFG_BENCH_HOT, 0);
    write_reg(CFG_BENCH_COLD, 127);
    run_random(100);
    settle();

    // High extremes, run with no idling on either side.
    steady = 1'b1;
    write_reg(CFG_AREA_THRESHOLD, 127);
    write_reg(CFG_PERSIST_LIMIT, 63);
    write_reg(CFG_BENCH_HOT, 127);
    write_reg(CFG_BENCH_COLD, 0);
    // Overtemperature events clear the counts but keep the sums, so repeated
    // almost-full hot windows push the hot sum into saturation.
    repeat (28) begin
      repeat (WIN_LEN - 1) add_item(MODE_NORMAL, 127, 127);
      add_item(MODE_OVERTEMP, 0, 0);
    end
    repeat (WIN_LEN) add_item(MODE_NORMAL, 127, 127);
    run_random(20);
    settle();
    steady = 1'b0;

    // Bypass: every sample becomes room temperature, even non-positive ones.
    write_reg(CFG_BYPASS, 1);
    write_reg(CFG_BENCH_HOT, 24);
    write_reg(CFG_AREA_THRESHOLD, 60);
    add_item(MODE_NORMAL, -128, 60);
    add_item(MODE_BENCH, 0, 0);
    add_item(MODE_BENCH, -128, -128);
    add_item(MODE_OVERTEMP, 5, 5);
    run_random(20);
    settle();

    // Mid-range settings; area threshold and benchmark limits chosen at random.
    write_reg(CFG_BYPASS, 0);
    write_reg(CFG_AREA_THRESHOLD, $urandom_range(60, 40));
    write_reg(CFG_PERSIST_LIMIT, 2);
    write_reg(CFG_BENCH_HOT, $urandom_range(100, 60));
    write_reg(CFG_BENCH_COLD, $urandom_range(80, 40));
    run_random(100);
    settle();

    if (faults == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== thermal_throttle_governor.f =====
src/ttg_pkg.sv
src/ttg_cfg_regs.sv
src/ttg_core.sv
src/ttg_out_reg.sv
src/thermal_throttle_governor.sv
verif/thermal_throttle_governor_tb.sv
